// File: hw/rtl/distance_vector_route_update_defines.svh
// ----------------------------------------------------------------------------
// Distance-vector route update: assertion macros
// Checks for the route update block; empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_UPDATE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_UPDATE_DEFINES_SVH

`ifndef SYNTHESIS
`define DVRU_ASSERT_NOW(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("route update check failed");
`define DVRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("route update sequence check failed");
`else
`define DVRU_ASSERT_NOW(lbl, clk, rst_n, prop)
`define DVRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/dvru_pkg.sv
// ----------------------------------------------------------------------------
// Distance-vector route update: package
// Shared types, action codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dvru_pkg;

    localparam logic [4:0] COST_INF = 5'd16;
    localparam logic [4:0] COST_ONE = 5'd1;

    localparam logic [1:0] ACT_UPDATED   = 2'd0;
    localparam logic [1:0] ACT_UNCHANGED = 2'd1;
    localparam logic [1:0] ACT_INSERTED  = 2'd2;
    localparam logic [1:0] ACT_DROPPED   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_MISS
    } t_state;

    typedef struct packed {
        logic start;
        logic issue;
        logic hit_commit;
        logic miss_commit;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic more;
        logic cmp_pend;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// File: hw/rtl/dvru_ctrl.sv
// ----------------------------------------------------------------------------
// Distance-vector route update: controller
// Sequences accept, table scan, hit or miss commit.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    input  wire dvru_pkg::t_status i_st,
    output logic             o_in_ready,
    output dvru_pkg::t_cmd   o_cmd
);

    dvru_pkg::t_state r_state;
    dvru_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dvru_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            dvru_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = dvru_pkg::S_SCAN;
                end
            end
            dvru_pkg::S_SCAN: begin
                if (i_st.hit) begin
                    n_state = dvru_pkg::S_HIT;
                end else if (i_st.more) begin
                    o_cmd.issue = 1'b1;
                end else if (!i_st.cmp_pend) begin
                    n_state = dvru_pkg::S_MISS;
                end
            end
            dvru_pkg::S_HIT: begin
                if (i_st.out_free) begin
                    o_cmd.hit_commit = 1'b1;
                    n_state          = dvru_pkg::S_IDLE;
                end
            end
            dvru_pkg::S_MISS: begin
                if (i_st.out_free) begin
                    o_cmd.miss_commit = 1'b1;
                    n_state           = dvru_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dvru_pkg::S_IDLE;
            end
        endcase
    end

`default_nettype wire
endmodule

// File: hw/rtl/dvru_dp.sv
// ----------------------------------------------------------------------------
// Distance-vector route update: datapath
// Route table memories, scan pointer, compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dvru_dp #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire dvru_pkg::t_cmd i_cmd,
    output dvru_pkg::t_status o_st,
    input  wire  [31:0]       i_neighbor_addr,
    input  wire  [31:0]       i_recv_iface,
    input  wire  [31:0]       i_adv_dest,
    input  wire  [4:0]        i_adv_cost,
    input  wire               i_out_ready,
    output logic              o_out_valid,
    output logic [1:0]        o_action,
    output logic [3:0]        o_entry_index,
    output logic [4:0]        o_route_cost,
    output logic [31:0]       o_route_next_hop
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [31:0] r_mem_dest [TABLE_DEPTH];
    logic [31:0] r_mem_hop  [TABLE_DEPTH];
    logic [31:0] r_mem_ifc  [TABLE_DEPTH];
    logic [4:0]  r_mem_cost [TABLE_DEPTH];

    logic [31:0] r_nbr;
    logic [31:0] r_ifc;
    logic [31:0] r_dst;
    logic [4:0]  r_cand;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_cmp_idx;
    logic          r_cmp_vld;
    logic [31:0] r_rd_dest;
    logic [31:0] r_rd_hop;
    logic [4:0]  r_rd_cost;

    logic        r_out_vld;
    logic [1:0]  r_act;
    logic [3:0]  r_eidx;
    logic [4:0]  r_cost;
    logic [31:0] r_hop;

    logic [4:0]    cand;
    logic          upd;
    logic          full;
    logic [AW-1:0] ins_addr;
    logic [4:0]    ins_cost;

    assign cand     = (i_adv_cost >= dvru_pkg::COST_INF) ? dvru_pkg::COST_INF
                                                         : i_adv_cost + 5'd1;
    assign upd      = (r_rd_cost > r_cand) || (r_rd_hop == r_nbr);
    assign full     = (r_count >= DEPTH_C);
    assign ins_addr = r_count[AW-1:0];
    assign ins_cost = (r_nbr == r_dst) ? dvru_pkg::COST_ONE : r_cand;

    assign o_st.hit      = r_cmp_vld && (r_rd_dest == r_dst);
    assign o_st.more     = (r_idx < r_count);
    assign o_st.cmp_pend = r_cmp_vld;
    assign o_st.out_free = !r_out_vld || i_out_ready;

    // latch the item and the compare index, then run the scan pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_nbr  <= i_neighbor_addr;
            r_ifc  <= i_recv_iface;
            r_dst  <= i_adv_dest;
            r_cand <= cand;
        end
        if (i_cmd.issue) begin
            r_cmp_idx <= r_idx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_count   <= '0;
        end else begin
            r_cmp_vld <= i_cmd.issue;
            if (i_cmd.start) begin
                r_idx <= '0;
            end else if (i_cmd.issue) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.miss_commit && !full) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // table read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_dest <= r_mem_dest[r_idx[AW-1:0]];
            r_rd_hop  <= r_mem_hop[r_idx[AW-1:0]];
            r_rd_cost <= r_mem_cost[r_idx[AW-1:0]];
        end
    end

    // table write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.hit_commit && upd) begin
            r_mem_hop[r_cmp_idx]  <= r_nbr;
            r_mem_cost[r_cmp_idx] <= r_cand;
        end else if (i_cmd.miss_commit && !full) begin
            r_mem_dest[ins_addr] <= r_dst;
            r_mem_hop[ins_addr]  <= r_nbr;
            r_mem_ifc[ins_addr]  <= r_ifc;
            r_mem_cost[ins_addr] <= ins_cost;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.hit_commit || i_cmd.miss_commit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hit_commit) begin
            r_eidx <= 4'(r_cmp_idx);
            if (upd) begin
                r_act  <= dvru_pkg::ACT_UPDATED;
                r_cost <= r_cand;
                r_hop  <= r_nbr;
            end else begin
                r_act  <= dvru_pkg::ACT_UNCHANGED;
                r_cost <= r_rd_cost;
                r_hop  <= r_rd_hop;
            end
        end else if (i_cmd.miss_commit) begin
            if (full) begin
                r_act  <= dvru_pkg::ACT_DROPPED;
                r_eidx <= '0;
                r_cost <= '0;
                r_hop  <= '0;
            end else begin
                r_act  <= dvru_pkg::ACT_INSERTED;
                r_eidx <= 4'(ins_addr);
                r_cost <= ins_cost;
                r_hop  <= r_nbr;
            end
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_action         = r_act;
    assign o_entry_index    = r_eidx;
    assign o_route_cost     = r_cost;
    assign o_route_next_hop = r_hop;

`default_nettype wire
endmodule

// File: hw/rtl/distance_vector_route_update.sv
// ----------------------------------------------------------------------------
// Distance-vector route update: top level
// Looks up an advertised route and updates or keeps, inserts or drops it.
//
//   Channel  Valid     Ready     Payload
//   input    i_valid   o_ready   i_neighbor_addr, i_recv_iface, i_adv_dest,
//                                i_adv_cost
//   result   o_valid   i_ready   o_action, o_entry_index, o_route_cost,
//                                o_route_next_hop
//
// A miss scans every table entry before the result register loads and a hit
// in slot k stops the scan at that slot, both set by the single table read
// port that the scan walks one slot per cycle. One route is in flight at a
// time; a new one is taken while the previous result waits in the output
// register. A result stall holds the commit until the output register frees.
// Reset empties the table (entry count to zero); no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "distance_vector_route_update_defines.svh"

module distance_vector_route_update #(
    parameter int TABLE_DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [31:0] i_neighbor_addr,
    input  wire  [31:0] i_recv_iface,
    input  wire  [31:0] i_adv_dest,
    input  wire  [4:0]  i_adv_cost,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_action,
    output logic [3:0]  o_entry_index,
    output logic [4:0]  o_route_cost,
    output logic [31:0] o_route_next_hop
);

    dvru_pkg::t_cmd    cmd;
    dvru_pkg::t_status st;

    logic res_drop;
    logic res_live;
    logic drop_zero;
    logic cost_ok;

    dvru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_st       (st),
        .o_in_ready (o_ready),
        .o_cmd      (cmd)
    );

    dvru_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_st             (st),
        .i_neighbor_addr  (i_neighbor_addr),
        .i_recv_iface     (i_recv_iface),
        .i_adv_dest       (i_adv_dest),
        .i_adv_cost       (i_adv_cost),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_action         (o_action),
        .o_entry_index    (o_entry_index),
        .o_route_cost     (o_route_cost),
        .o_route_next_hop (o_route_next_hop)
    );

    assign res_drop  = o_valid && (o_action == dvru_pkg::ACT_DROPPED);
    assign res_live  = o_valid && (o_action != dvru_pkg::ACT_DROPPED);
    assign drop_zero = (o_entry_index == 4'd0) && (o_route_cost == 5'd0)
                       && (o_route_next_hop == 32'd0);
    assign cost_ok   = (o_route_cost != 5'd0) && (o_route_cost <= dvru_pkg::COST_INF);

    `DVRU_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `DVRU_ASSERT_NOW(a_hit_stops_scan, i_clk, i_rst_n, st.hit |-> !cmd.issue)
    `DVRU_ASSERT_NOW(a_drop_zero, i_clk, i_rst_n, res_drop |-> drop_zero)
    `DVRU_ASSERT_NOW(a_cost_range, i_clk, i_rst_n, res_live |-> cost_ok)

`default_nettype wire
endmodule
